// ===== rtl/lidar_scan_to_points_defines.svh =====
// assertion helpers for the scan-to-points block
`ifndef LIDAR_SCAN_TO_POINTS_DEFINES_SVH
`define LIDAR_SCAN_TO_POINTS_DEFINES_SVH

// same-cycle implication, checked on clk, quiet while arst_n is low
`define LSTP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lstp assertion failed");

// next-cycle implication
`define LSTP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lstp assertion failed");

`endif

// ===== rtl/lstp_pkg.sv =====
package lstp_pkg;

	localparam int ANGLE_BITS_DEF = 16;
	localparam int RANGE_BITS_DEF = 16;

	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int OUT_W     = 20;

	localparam int QUEUE_DEPTH = 4;

	localparam int CORDIC_STEPS = 14;
	localparam int ITER_W       = $clog2(CORDIC_STEPS);
	localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_STEPS - 1);
	localparam logic signed [17:0] CORDIC_X0 = 18'sd9949;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ANGLE_START = 3'd0,
		REG_ANGLE_STEP  = 3'd1,
		REG_WIN_LO      = 3'd2,
		REG_WIN_HI      = 3'd3,
		REG_ROT_ROW_X   = 3'd4,
		REG_ROT_ROW_Y   = 3'd5,
		REG_OFFSET_X    = 3'd6,
		REG_OFFSET_Y    = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0]        angle_start;
		logic signed [15:0] angle_step;
		logic [15:0]        win_lo;
		logic [15:0]        win_hi;
		logic [31:0]        rot_row_x;
		logic [31:0]        rot_row_y;
		logic signed [15:0] offset_x;
		logic signed [15:0] offset_y;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		angle_start: 16'd0,
		angle_step:  16'sd0,
		win_lo:      16'd0,
		win_hi:      16'hFFFF,
		rot_row_x:   32'h0000_4000,
		rot_row_y:   32'h4000_0000,
		offset_x:    16'sd0,
		offset_y:    16'sd0
	};

	// one classified sample waiting for the back end
	typedef struct packed {
		logic [15:0] a16;
		logic [15:0] range;
		logic        keep;
		logic        last;
	} q_entry_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_ROT,
		B_CS,
		B_MUL,
		B_PROD,
		B_SUM
	} back_state_t;

	// arctangent of 2^-i in 16-bit binary angle units
	function automatic logic [13:0] cordic_atan(input logic [ITER_W-1:0] i);
		logic [13:0] v;
		case (i)
			4'd0:    v = 14'd8192;
			4'd1:    v = 14'd4836;
			4'd2:    v = 14'd2555;
			4'd3:    v = 14'd1297;
			4'd4:    v = 14'd651;
			4'd5:    v = 14'd326;
			4'd6:    v = 14'd163;
			4'd7:    v = 14'd81;
			4'd8:    v = 14'd41;
			4'd9:    v = 14'd20;
			4'd10:   v = 14'd10;
			4'd11:   v = 14'd5;
			4'd12:   v = 14'd3;
			4'd13:   v = 14'd1;
			default: v = 14'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/lstp_queue.sv =====
module lstp_queue import lstp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr,
	input  q_entry_t wr_entry,
	input  logic     rd,
	output q_entry_t rd_entry,
	output logic     empty,
	output logic     full
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	q_entry_t           mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr;
	logic               do_rd;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign do_wr    = wr && !full;
	assign do_rd    = rd && !empty;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

// ===== rtl/lstp_front.sv =====
module lstp_front import lstp_pkg::*; #(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF,
	parameter int RANGE_BITS = RANGE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        push,
	input  logic [15:0] range_mm,
	input  logic        scan_start,
	input  logic        scan_end,
	input  logic        q_full,
	output logic        q_push,
	output q_entry_t    q_entry
);

	logic [ANGLE_BITS-1:0] beam_angle_q;
	logic [ANGLE_BITS-1:0] start_a;
	logic [ANGLE_BITS-1:0] step_a;
	logic [ANGLE_BITS-1:0] cur_a;
	logic [15:0]           a16;
	logic [15:0]           r16;

	generate
		if (ANGLE_BITS > 16) begin : g_wide_angle
			assign start_a = {{(ANGLE_BITS-16){1'b0}}, cfg.angle_start};
			assign step_a  = {{(ANGLE_BITS-16){cfg.angle_step[15]}}, cfg.angle_step};
		end else begin : g_narrow_angle
			assign start_a = cfg.angle_start[ANGLE_BITS-1:0];
			assign step_a  = cfg.angle_step[ANGLE_BITS-1:0];
		end
		if (ANGLE_BITS >= 16) begin : g_a16_top
			assign a16 = cur_a[ANGLE_BITS-1 -: 16];
		end else begin : g_a16_shift
			assign a16 = {cur_a, {(16-ANGLE_BITS){1'b0}}};
		end
		if (RANGE_BITS >= 16) begin : g_full_range
			assign r16 = range_mm;
		end else begin : g_masked_range
			assign r16 = {{(16-RANGE_BITS){1'b0}}, range_mm[RANGE_BITS-1:0]};
		end
	endgenerate

	assign cur_a  = scan_start ? start_a : beam_angle_q;
	assign q_push = push && !q_full;

	always_comb begin
		q_entry.a16   = a16;
		q_entry.range = r16;
		q_entry.keep  = (r16 >= cfg.win_lo) && (r16 <= cfg.win_hi);
		q_entry.last  = scan_end;
	end

	// angle advances on every accepted sample, kept or not
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_angle_q <= '0;
		end else if (q_push) begin
			beam_angle_q <= cur_a + step_a;
		end
	end

endmodule

// ===== rtl/lstp_back.sv =====
module lstp_back import lstp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    q_empty,
	input  q_entry_t                q_entry,
	output logic                    q_pop,
	input  logic                    pop,
	output logic                    empty,
	output logic signed [OUT_W-1:0] point_x,
	output logic signed [OUT_W-1:0] point_y,
	output logic                    kept,
	output logic                    last_point
);

	localparam logic signed [22:0] OUT_HI = 23'sd524287;
	localparam logic signed [22:0] OUT_LO = -23'sd524288;

	back_state_t state_q, state_d;

	logic                    start_item;
	logic                    out_load;
	logic [ITER_W-1:0]       iter_q;
	logic signed [17:0]      x_q, y_q, z_q;
	logic                    flip_q;
	logic [15:0]             r_q;
	logic                    keep_q;
	logic                    last_q;
	logic signed [15:0]      c_q, s_q;
	logic signed [32:0]      rc_q, rs_q;
	logic signed [48:0]      pxx_q, pxy_q, pyx_q, pyy_q;
	logic                    out_valid_q;
	logic signed [OUT_W-1:0] point_x_q, point_y_q;
	logic                    kept_q, last_point_q;

	logic [15:0]             a_rot;
	logic                    a_flip;
	logic signed [17:0]      dx, dy, atan_v;
	logic signed [49:0]      acc_x, acc_y;
	logic signed [22:0]      v_x, v_y;

	function automatic logic signed [15:0] clamp_q14(input logic signed [17:0] v,
			input logic neg);
		logic signed [17:0] c;
		c = v;
		if (v > 18'sd16384) begin
			c = 18'sd16384;
		end else if (v < -18'sd16384) begin
			c = -18'sd16384;
		end
		if (neg) begin
			c = -c;
		end
		return c[15:0];
	endfunction

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [22:0] v);
		logic signed [22:0] c;
		c = v;
		if (v > OUT_HI) begin
			c = OUT_HI;
		end else if (v < OUT_LO) begin
			c = OUT_LO;
		end
		return c[OUT_W-1:0];
	endfunction

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!q_empty) state_d = B_ROT;
			end
			B_ROT: begin
				if (iter_q == LAST_ITER) state_d = B_CS;
			end
			B_CS:   state_d = B_MUL;
			B_MUL:  state_d = B_PROD;
			B_PROD: state_d = B_SUM;
			B_SUM: begin
				if (!out_valid_q || pop) state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		start_item = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			B_IDLE:  start_item = !q_empty;
			B_SUM:   out_load   = !out_valid_q || pop;
			default: begin
				start_item = 1'b0;
				out_load   = 1'b0;
			end
		endcase
	end

	assign q_pop = start_item;

	// left half-plane is turned by half a turn, results negated later
	assign a_flip = q_entry.a16[15] ^ q_entry.a16[14];
	assign a_rot  = a_flip ? {~q_entry.a16[15], q_entry.a16[14:0]} : q_entry.a16;

	assign dx     = y_q >>> iter_q;
	assign dy     = x_q >>> iter_q;
	assign atan_v = $signed({4'd0, cordic_atan(iter_q)});

	assign acc_x = 50'(pxx_q) + 50'(pxy_q) + 50'sd134217728;
	assign acc_y = 50'(pyx_q) + 50'(pyy_q) + 50'sd134217728;
	assign v_x   = $signed({acc_x[49], acc_x[49:28]}) + 23'(cfg.offset_x);
	assign v_y   = $signed({acc_y[49], acc_y[49:28]}) + 23'(cfg.offset_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_item) begin
			x_q    <= CORDIC_X0;
			y_q    <= '0;
			z_q    <= {{2{a_rot[15]}}, a_rot};
			iter_q <= '0;
			flip_q <= a_flip;
			r_q    <= q_entry.range;
			keep_q <= q_entry.keep;
			last_q <= q_entry.last;
		end else if (state_q == B_ROT) begin
			iter_q <= iter_q + 1'b1;
			if (!z_q[17]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_v;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_v;
			end
		end
		if (state_q == B_CS) begin
			c_q <= clamp_q14(x_q, flip_q);
			s_q <= clamp_q14(y_q, flip_q);
		end
		if (state_q == B_MUL) begin
			rc_q <= $signed({1'b0, r_q}) * c_q;
			rs_q <= $signed({1'b0, r_q}) * s_q;
		end
		if (state_q == B_PROD) begin
			pxx_q <= rc_q * $signed(cfg.rot_row_x[15:0]);
			pxy_q <= rs_q * $signed(cfg.rot_row_x[31:16]);
			pyx_q <= rc_q * $signed(cfg.rot_row_y[15:0]);
			pyy_q <= rs_q * $signed(cfg.rot_row_y[31:16]);
		end
		if (out_load) begin
			point_x_q    <= keep_q ? sat_out(v_x) : '0;
			point_y_q    <= keep_q ? sat_out(v_y) : '0;
			kept_q       <= keep_q;
			last_point_q <= last_q;
		end
	end

	assign empty      = !out_valid_q;
	assign point_x    = point_x_q;
	assign point_y    = point_y_q;
	assign kept       = kept_q;
	assign last_point = last_point_q;

endmodule

// ===== rtl/lidar_scan_to_points.sv =====
// path: an accepted sample passes the queue, then back-end states idle, rot, cs, mul,
// prod and sum, before empty goes low; a new item starts only when the last is done,
// as the 14-step cordic unit is shared by all items; up to 4 classified items queue
// ahead of it, 1 result waits at the output while the next is worked on
// reset: arst_n clears the beam angle, queue, back-end state and output valid,
// and loads the registers with their default values; no clearing pass
`include "lidar_scan_to_points_defines.svh"

module lidar_scan_to_points import lstp_pkg::*; #(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF,
	parameter int RANGE_BITS = RANGE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wen,
	input  logic [CFG_IDX_W-1:0]    cfg_idx,
	input  logic [CFG_W-1:0]        cfg_wdata,
	input  logic                    push,
	output logic                    full,
	input  logic [15:0]             range_mm,
	input  logic                    scan_start,
	input  logic                    scan_end,
	output logic                    empty,
	input  logic                    pop,
	output logic signed [OUT_W-1:0] point_x,
	output logic signed [OUT_W-1:0] point_y,
	output logic                    kept,
	output logic                    last_point
);

	cfg_t     cfg_q;
	logic     q_push, q_pop, q_empty, q_full;
	q_entry_t q_wr_entry, q_rd_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wen) begin
			case (cfg_reg_t'(cfg_idx))
				REG_ANGLE_START: cfg_q.angle_start <= cfg_wdata[15:0];
				REG_ANGLE_STEP:  cfg_q.angle_step  <= cfg_wdata[15:0];
				REG_WIN_LO:      cfg_q.win_lo      <= cfg_wdata[15:0];
				REG_WIN_HI:      cfg_q.win_hi      <= cfg_wdata[15:0];
				REG_ROT_ROW_X:   cfg_q.rot_row_x   <= cfg_wdata;
				REG_ROT_ROW_Y:   cfg_q.rot_row_y   <= cfg_wdata;
				REG_OFFSET_X:    cfg_q.offset_x    <= cfg_wdata[15:0];
				REG_OFFSET_Y:    cfg_q.offset_y    <= cfg_wdata[15:0];
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	assign full = q_full;

	lstp_front #(
		.ANGLE_BITS(ANGLE_BITS),
		.RANGE_BITS(RANGE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.range_mm  (range_mm),
		.scan_start(scan_start),
		.scan_end  (scan_end),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (q_wr_entry)
	);

	lstp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_push),
		.wr_entry(q_wr_entry),
		.rd      (q_pop),
		.rd_entry(q_rd_entry),
		.empty   (q_empty),
		.full    (q_full)
	);

	lstp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_entry   (q_rd_entry),
		.q_pop     (q_pop),
		.pop       (pop),
		.empty     (empty),
		.point_x   (point_x),
		.point_y   (point_y),
		.kept      (kept),
		.last_point(last_point)
	);

	// an accepted sample is waiting in the queue on the next cycle
	`LSTP_ASSERT_NEXT(a_push_fills_queue, push && !full, !q_empty)
	// the back end only takes from a queue that holds something
	`LSTP_ASSERT_NOW(a_pop_nonempty, q_pop, !q_empty)
	// a rejected sample shows a zero point
	`LSTP_ASSERT_NOW(a_rejected_zero, !empty && !kept, point_x == '0 && point_y == '0)

endmodule
